// ===== hdl/nearest_neighbor_frame_scaler_core_defines.svh =====
// Assertion macros for the frame scaler. All checks sample on clk_i and are
// switched off while rst_ni is low.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_CORE_DEFINES_SVH

`define NNFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define NNFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nnfs_pkg.sv =====
package nnfs_pkg;

  localparam int unsigned DIM_W   = 9;
  localparam int unsigned SCALE_W = 15;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned CFG_IDX_W = 2;
  // Output positions reach 511 * 100.0 at most.
  localparam int unsigned EMIT_W  = DIM_W + SCALE_W - 8;
  // Dividend is an output position times 256.
  localparam int unsigned NUM_W   = EMIT_W + 8;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned PIX_W   = 24;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam logic [SCALE_W-1:0] SCALE_MAX = 15'd25600;
  localparam logic [DIM_W-1:0]   DIM_RESET = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd256;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   row_num;
    logic [NUM_W-1:0]   col_num;
    logic [SCALE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] row_quo;
    logic [NUM_W-1:0] col_quo;
  } div_rsp_t;

endpackage

// ===== hdl/nnfs_div.sv =====
// Two-lane restoring divider: row and column quotients share one step
// counter and one divisor, one quotient bit per lane per cycle.
module nnfs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nnfs_pkg::div_req_t req_i,
  output nnfs_pkg::div_rsp_t rsp_o
);

  logic [nnfs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [nnfs_pkg::SCALE_W-1:0]   dvs_q;
  logic [nnfs_pkg::SCALE_W-1:0]   rrem_q, rrem_d, crem_q, crem_d;
  logic [nnfs_pkg::NUM_W-1:0]     rquo_q, rquo_d, cquo_q, cquo_d;
  logic [nnfs_pkg::SCALE_W:0]     rtry, ctry;
  logic                           rge, cge;

  always_comb begin
    rtry = {rrem_q, rquo_q[nnfs_pkg::NUM_W-1]};
    ctry = {crem_q, cquo_q[nnfs_pkg::NUM_W-1]};
    rge  = rtry >= {1'b0, dvs_q};
    cge  = ctry >= {1'b0, dvs_q};
    rrem_d = rge ? nnfs_pkg::SCALE_W'(rtry - {1'b0, dvs_q})
                 : nnfs_pkg::SCALE_W'(rtry);
    crem_d = cge ? nnfs_pkg::SCALE_W'(ctry - {1'b0, dvs_q})
                 : nnfs_pkg::SCALE_W'(ctry);
    rquo_d = {rquo_q[nnfs_pkg::NUM_W-2:0], rge};
    cquo_d = {cquo_q[nnfs_pkg::NUM_W-2:0], cge};
    done_d = (cnt_q == nnfs_pkg::DIV_CNT_W'(1));
    if (req_i.start) begin
      cnt_d = nnfs_pkg::DIV_CNT_W'(nnfs_pkg::NUM_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - nnfs_pkg::DIV_CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q  <= req_i.divisor;
      rrem_q <= '0;
      crem_q <= '0;
      rquo_q <= req_i.row_num;
      cquo_q <= req_i.col_num;
    end else if (cnt_q != '0) begin
      rrem_q <= rrem_d;
      crem_q <= crem_d;
      rquo_q <= rquo_d;
      cquo_q <= cquo_d;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.row_quo = rquo_q;
  assign rsp_o.col_quo = cquo_q;

endmodule

// ===== hdl/nnfs_store.sv =====
// Frame store: one write port, one read port with registered read data.
module nnfs_store #(
  parameter int unsigned DEPTH  = nnfs_pkg::MAX_WIDTH_DEF * nnfs_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned ADDR_W = 16
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [nnfs_pkg::PIX_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [nnfs_pkg::PIX_W-1:0]  rdata_o
);

  logic [nnfs_pkg::PIX_W-1:0] mem [DEPTH];
  logic [nnfs_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nearest_neighbor_frame_scaler_core.sv =====
// Loads are written to the frame store as they are accepted, one word per cycle while no fetch
// is in progress. A fetch that yields nothing does not stall the input; a fetch that yields a
// pixel finds the source position in 24 divider steps, then makes one frame store read and
// loads one output register, which waits while the output is stalled; input stall stays high
// until the pixel enters the output register. Reset clears the counters, flags and output valid
// and restores the registers to 256, 256 and 1.0; the frame store is not cleared.
module nearest_neighbor_frame_scaler_core #(
  parameter int unsigned MAX_WIDTH  = nnfs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = nnfs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  nnfs_pkg::in_word_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nnfs_pkg::out_word_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [nnfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnfs_pkg::CFG_W-1:0]      cfg_wdata_i
);

`include "nearest_neighbor_frame_scaler_core_defines.svh"

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW     = nnfs_pkg::DIM_W;
  localparam int unsigned EW     = nnfs_pkg::EMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  typedef struct packed {
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       frame_end;
  } meta_t;

  state_e state_q, state_d;

  logic [DW-1:0]                src_width_q, src_height_q;
  logic [nnfs_pkg::SCALE_W-1:0] scale_q;
  logic [DW-1:0]                load_row_q, load_row_d, load_col_q, load_col_d;
  logic                         loaded_q, loaded_d;
  logic [EW-1:0]                emit_row_q, emit_row_d, emit_col_q, emit_col_d;
  meta_t                        meta_q, meta_d;
  logic                         out_valid_q, out_valid_d;
  nnfs_pkg::out_word_t          out_q;

  logic [DW-1:0]                w_eff, h_eff;
  logic [nnfs_pkg::SCALE_W-1:0] s_eff;
  logic [DW+nnfs_pkg::SCALE_W-1:0] ow_prod, oh_prod;
  logic [EW-1:0]                ow, oh;

  logic                         in_acc, out_free;
  logic [DW-1:0]                lr0, lc0, lr, lc, lc_inc, lr_inc;
  logic                         last_col, last_row;

  nnfs_pkg::div_req_t           div_req;
  nnfs_pkg::div_rsp_t           div_rsp;
  logic [DW-1:0]                src_r, src_c;

  logic                         mem_we, mem_re;
  logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
  logic [nnfs_pkg::PIX_W-1:0]   mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= nnfs_pkg::DIM_RESET;
      src_height_q <= nnfs_pkg::DIM_RESET;
      scale_q      <= nnfs_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nnfs_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i[DW-1:0];
        nnfs_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_wdata_i[DW-1:0];
        nnfs_pkg::CFG_SCALE:      scale_q      <= cfg_wdata_i[nnfs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame geometry.
  always_comb begin
    if (src_width_q == '0) begin
      w_eff = DW'(1);
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = src_width_q;
    end
    if (src_height_q == '0) begin
      h_eff = DW'(1);
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = src_height_q;
    end
    s_eff   = (scale_q > nnfs_pkg::SCALE_MAX) ? nnfs_pkg::SCALE_MAX : scale_q;
    ow_prod = w_eff * s_eff;
    oh_prod = h_eff * s_eff;
    ow      = ow_prod[DW+nnfs_pkg::SCALE_W-1:8];
    oh      = oh_prod[DW+nnfs_pkg::SCALE_W-1:8];
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Load position, with a wrap when the position lies outside the current size.
  always_comb begin
    lr0    = loaded_q ? '0 : load_row_q;
    lc0    = loaded_q ? '0 : load_col_q;
    lr     = (lr0 >= h_eff) ? '0 : lr0;
    lc     = (lc0 >= w_eff) ? '0 : lc0;
    lc_inc = lc + DW'(1);
    lr_inc = lr + DW'(1);
    last_col = (emit_col_q == ow - EW'(1));
    last_row = (emit_row_q == oh - EW'(1));
  end

  always_comb begin
    state_d    = state_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    loaded_d   = loaded_q;
    emit_row_d = emit_row_q;
    emit_col_d = emit_col_q;
    meta_d     = meta_q;
    div_req.start   = 1'b0;
    div_req.row_num = {emit_row_q, 8'h00};
    div_req.col_num = {emit_col_q, 8'h00};
    div_req.divisor = s_eff;
    mem_we = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.cmd == nnfs_pkg::CMD_LOAD) begin
          mem_we = 1'b1;
          if (loaded_q) begin
            emit_row_d = '0;
            emit_col_d = '0;
          end
          loaded_d   = 1'b0;
          load_row_d = lr;
          load_col_d = lc_inc;
          if (lc_inc >= w_eff) begin
            load_col_d = '0;
            load_row_d = lr_inc;
            if (lr_inc >= h_eff) begin
              load_row_d = '0;
              loaded_d   = 1'b1;
              emit_row_d = '0;
              emit_col_d = '0;
            end
          end
        end else if (in_acc && loaded_q && ow != '0 && oh != '0) begin
          if (emit_row_q >= oh || emit_col_q >= ow) begin
            // Position left behind by a smaller size: the frame is over.
            loaded_d   = 1'b0;
            emit_row_d = '0;
            emit_col_d = '0;
          end else begin
            div_req.start    = 1'b1;
            state_d          = ST_DIV;
            meta_d.row_end   = last_col;
            meta_d.pad_bytes = last_col ? ow[1:0] : 2'd0;
            meta_d.frame_end = last_col && last_row;
            if (last_col) begin
              emit_col_d = '0;
              if (last_row) begin
                emit_row_d = '0;
                loaded_d   = 1'b0;
              end else begin
                emit_row_d = emit_row_q + EW'(1);
              end
            end else begin
              emit_col_d = emit_col_q + EW'(1);
            end
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Source position from the quotients, kept inside the source frame.
  always_comb begin
    src_r = (div_rsp.row_quo >= nnfs_pkg::NUM_W'(h_eff)) ? h_eff - DW'(1)
                                                        : div_rsp.row_quo[DW-1:0];
    src_c = (div_rsp.col_quo >= nnfs_pkg::NUM_W'(w_eff)) ? w_eff - DW'(1)
                                                        : div_rsp.col_quo[DW-1:0];
    mem_re    = (state_q == ST_DIV) && div_rsp.done;
    mem_raddr = ADDR_W'(src_r * MAX_WIDTH + src_c);
    mem_waddr = ADDR_W'(lr * MAX_WIDTH + lc);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_OUT && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_row_q  <= '0;
      load_col_q  <= '0;
      loaded_q    <= 1'b0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      loaded_q    <= loaded_d;
      emit_row_q  <= emit_row_d;
      emit_col_q  <= emit_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
    if (state_q == ST_OUT && out_free) begin
      out_q.out_blue  <= mem_rdata[7:0];
      out_q.out_green <= mem_rdata[15:8];
      out_q.out_red   <= mem_rdata[23:16];
      out_q.row_end   <= meta_q.row_end;
      out_q.pad_bytes <= meta_q.pad_bytes;
      out_q.frame_end <= meta_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  nnfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  nnfs_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  `NNFS_ASSERT(a_done_in_div, !div_rsp.done || state_q == ST_DIV, "divider done outside DIV")
  `NNFS_ASSERT(a_no_rw_clash, !(mem_we && mem_re), "frame store read and write collide")
  `NNFS_ASSERT_NEXT(a_out_load, state_q == ST_OUT && out_free, out_valid_q, "result word lost")
  `NNFS_ASSERT_NEXT(a_fetch_div, in_acc && div_req.start, state_q == ST_DIV, "fetch did not divide")

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned FETCH_CAP     = 80;
  localparam int unsigned LIMIT_CYCLES  = 3000000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  nnfs_pkg::in_word_t             in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  nnfs_pkg::out_word_t            out_data_o;
  logic                           cfg_we_i;
  logic [nnfs_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [nnfs_pkg::CFG_W-1:0]     cfg_wdata_i;

  nearest_neighbor_frame_scaler_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be sent, and output pixels the scaler still owes us.
  nnfs_pkg::in_word_t    pending_words[$];
  nnfs_pkg::out_word_t   expected_pixels[$];

  // Shadow of the scaler: register values, frame store and positions.
  logic [23:0] shadow_frame [0:nnfs_pkg::MAX_WIDTH_DEF*nnfs_pkg::MAX_HEIGHT_DEF-1];
  logic [nnfs_pkg::DIM_W-1:0]   cfg_width  = nnfs_pkg::DIM_RESET;
  logic [nnfs_pkg::DIM_W-1:0]   cfg_height = nnfs_pkg::DIM_RESET;
  logic [nnfs_pkg::SCALE_W-1:0] cfg_scale  = nnfs_pkg::SCALE_RESET;
  bit                 frame_ready = 1'b0;
  int unsigned        load_r = 0, load_c = 0, emit_r = 0, emit_c = 0;

  bit          word_taken = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_count = 0;
  int unsigned burst_left = 0, gap_left = 0;
  int unsigned rx_cycle = 0, rx_mode = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned loads_seen = 0, fetches_seen = 0, pixels_checked = 0, frames_done = 0;
  int unsigned settings_used = 0;

  task automatic predict_word(input nnfs_pkg::in_word_t w);
    int unsigned wd, ht, sf, ow, oh, sr, sc;
    logic [23:0] pix;
    nnfs_pkg::out_word_t px;
    wd = (cfg_width == 0) ? 1 : ((cfg_width > nnfs_pkg::MAX_WIDTH_DEF)
                                 ? nnfs_pkg::MAX_WIDTH_DEF : cfg_width);
    ht = (cfg_height == 0) ? 1 : ((cfg_height > nnfs_pkg::MAX_HEIGHT_DEF)
                                  ? nnfs_pkg::MAX_HEIGHT_DEF : cfg_height);
    sf = (cfg_scale > nnfs_pkg::SCALE_MAX) ? nnfs_pkg::SCALE_MAX : cfg_scale;
    ow = (wd * sf) >> 8;
    oh = (ht * sf) >> 8;
    if (w.cmd == nnfs_pkg::CMD_LOAD) begin
      loads_seen++;
      // A load on a finished frame throws away whatever output was not fetched.
      if (frame_ready) begin
        frame_ready = 1'b0;
        load_r = 0;
        load_c = 0;
        emit_r = 0;
        emit_c = 0;
      end
      if (load_r >= ht) load_r = 0;
      if (load_c >= wd) load_c = 0;
      shadow_frame[load_r * nnfs_pkg::MAX_WIDTH_DEF + load_c] =
        {w.in_red, w.in_green, w.in_blue};
      load_c++;
      if (load_c >= wd) begin
        load_c = 0;
        load_r++;
        if (load_r >= ht) begin
          load_r = 0;
          frame_ready = 1'b1;
          emit_r = 0;
          emit_c = 0;
        end
      end
    end else begin
      fetches_seen++;
      if (frame_ready && ow != 0 && oh != 0) begin
        if (emit_r >= oh || emit_c >= ow) begin
          // The output size shrank under the position: the frame is over.
          frame_ready = 1'b0;
          emit_r = 0;
          emit_c = 0;
        end else begin
          sr = (emit_r << 8) / sf;
          sc = (emit_c << 8) / sf;
          if (sr >= ht) sr = ht - 1;
          if (sc >= wd) sc = wd - 1;
          pix = shadow_frame[sr * nnfs_pkg::MAX_WIDTH_DEF + sc];
          px.out_blue  = pix[7:0];
          px.out_green = pix[15:8];
          px.out_red   = pix[23:16];
          px.row_end   = (emit_c == ow - 1);
          px.pad_bytes = px.row_end ? 2'((4 - (3 * ow) % 4) % 4) : 2'd0;
          px.frame_end = px.row_end && (emit_r == oh - 1);
          expected_pixels.push_back(px);
          if (px.row_end) begin
            emit_c = 0;
            if (px.frame_end) begin
              emit_r = 0;
              frame_ready = 1'b0;
            end else begin
              emit_r++;
            end
          end else begin
            emit_c++;
          end
        end
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin : drive_words
    logic               nxt_valid;
    nnfs_pkg::in_word_t nxt_word;
    nxt_valid = in_valid_i;
    nxt_word  = in_data_i;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      nxt_valid = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 12);
        gap_left = $urandom_range(0, 6);
      end
      if (burst_left > 0) begin
        if (pending_words.size() > 0) begin
          nxt_word  = pending_words.pop_front();
          nxt_valid = 1'b1;
          burst_left--;
        end
      end else begin
        gap_left--;
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_word;
  end

  // Receiver: it switches among three stall patterns, with one long hold-off on request.
  always @(negedge clk_i) begin : drive_stall
    logic nxt_stall;
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: nxt_stall = 1'b0;
      1: nxt_stall = 1'($urandom_range(0, 1));
      default: nxt_stall = (rx_cycle % 7) < 3;
    endcase
    if (hold_req && hold_count < HOLD_CYCLES) begin
      nxt_stall = 1'b1;
      hold_count++;
    end
    out_stall_i <= nxt_stall;
  end

  always @(posedge clk_i) begin : watch_ports
    nnfs_pkg::out_word_t want;
    if (!rst_ni) begin
      word_taken = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("output word arrived with no pixel expected");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (want.frame_end) frames_done++;
          if (out_data_o.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, out_data_o.out_blue);
            fail_count++;
          end
          if (out_data_o.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, out_data_o.out_green);
            fail_count++;
          end
          if (out_data_o.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, out_data_o.out_red);
            fail_count++;
          end
          if (out_data_o.row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, out_data_o.row_end);
            fail_count++;
          end
          if (out_data_o.pad_bytes !== want.pad_bytes) begin
            $error("pad_bytes: expected %0d, got %0d", want.pad_bytes, out_data_o.pad_bytes);
            fail_count++;
          end
          if (out_data_o.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_data_o.frame_end);
            fail_count++;
          end
        end
      end
      word_taken = in_valid_i && !in_stall_o;
      if (word_taken) predict_word(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_loads(input int unsigned n);
    repeat (n) begin
      pending_words.push_back(nnfs_pkg::in_word_t'({nnfs_pkg::CMD_LOAD, 24'($urandom)}));
    end
  endtask

  task automatic queue_fetches(input int unsigned n);
    repeat (n) begin
      pending_words.push_back(nnfs_pkg::in_word_t'({nnfs_pkg::CMD_FETCH, 24'($urandom)}));
    end
  endtask

  // Returns at a rising edge once every word is sent, every pixel is back, and
  // any fetch that gives no pixel has had time to finish.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [nnfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nnfs_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      nnfs_pkg::CFG_SRC_WIDTH:  cfg_width  = val[nnfs_pkg::DIM_W-1:0];
      nnfs_pkg::CFG_SRC_HEIGHT: cfg_height = val[nnfs_pkg::DIM_W-1:0];
      nnfs_pkg::CFG_SCALE:      cfg_scale  = val[nnfs_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Bits above the dimension width are don't-care, so they carry noise.
  task automatic begin_phase(input int unsigned wv, input int unsigned hv,
                             input int unsigned sv);
    settle();
    write_reg(nnfs_pkg::CFG_SRC_WIDTH,
              nnfs_pkg::CFG_W'(($urandom_range(0, 63) << nnfs_pkg::DIM_W) | wv));
    write_reg(nnfs_pkg::CFG_SRC_HEIGHT,
              nnfs_pkg::CFG_W'(($urandom_range(0, 63) << nnfs_pkg::DIM_W) | hv));
    write_reg(nnfs_pkg::CFG_SCALE, nnfs_pkg::CFG_W'(sv));
    settings_used++;
    @(posedge clk_i);
  endtask

  initial begin : run_stimulus
    int unsigned wv, hv, sv, we, he, se, ow, oh, n_fetch, n, style;
    int unsigned random_items;
    random_items = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = nnfs_pkg::CFG_SRC_WIDTH;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Fetches on an empty store are ignored. Then the top row, the left column and a
    // small corner block are loaded; later phases only read inside that area.
    queue_fetches(2);
    begin_phase(256, 1, 256);
    pending_words.push_back(nnfs_pkg::in_word_t'({nnfs_pkg::CMD_LOAD, 24'h000000}));
    pending_words.push_back(nnfs_pkg::in_word_t'({nnfs_pkg::CMD_LOAD, 24'hFFFFFF}));
    queue_loads(nnfs_pkg::MAX_WIDTH_DEF - 2);
    queue_fetches(4);
    begin_phase(1, 256, 256);
    queue_loads(nnfs_pkg::MAX_HEIGHT_DEF);
    begin_phase(5, 5, 256);
    queue_loads(25);

    // Small frame read to the end and one past it, under a long receiver hold-off.
    begin_phase(3, 2, 512);
    hold_req = 1'b1;
    pending_words.push_back(nnfs_pkg::in_word_t'({nnfs_pkg::CMD_LOAD, 24'hFFFFFF}));
    pending_words.push_back(nnfs_pkg::in_word_t'({nnfs_pkg::CMD_LOAD, 24'h000000}));
    queue_loads(4);
    queue_fetches(25);

    // Zero dimensions act as one; zero scale gives an empty output.
    begin_phase(0, 0, 0);
    queue_loads(1);
    queue_fetches(1);
    // Oversized scale saturates; then a load on a loaded frame restarts it.
    begin_phase(0, 0, 32767);
    queue_fetches(3);
    queue_loads(1);
    queue_fetches(2);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: wv = 0;
        1: wv = 511;
        2: wv = 256;
        3: wv = $urandom_range(257, 510);
        default: wv = $urandom_range(1, 5);
      endcase
      we = (wv == 0) ? 1 : ((wv > nnfs_pkg::MAX_WIDTH_DEF) ? nnfs_pkg::MAX_WIDTH_DEF : wv);
      if (we > 8) begin
        hv = $urandom_range(0, 1);
      end else begin
        case ($urandom_range(0, 7))
          0: hv = 0;
          1: hv = 511;
          2: hv = 256;
          default: hv = $urandom_range(1, 5);
        endcase
      end
      he = (hv == 0) ? 1 : ((hv > nnfs_pkg::MAX_HEIGHT_DEF) ? nnfs_pkg::MAX_HEIGHT_DEF : hv);
      // Keep the frame to one column when the height is large.
      if (he > 8) begin
        wv = 1;
        we = wv;
      end
      case ($urandom_range(0, 9))
        0: sv = 0;
        1: sv = 1;
        2: sv = nnfs_pkg::SCALE_MAX;
        3: sv = $urandom_range(nnfs_pkg::SCALE_MAX + 1, 32767);
        4: sv = $urandom_range(0, 32767);
        default: sv = $urandom_range(32, 640);
      endcase
      se = (sv > nnfs_pkg::SCALE_MAX) ? nnfs_pkg::SCALE_MAX : sv;
      ow = (we * se) >> 8;
      oh = (he * se) >> 8;
      begin_phase(wv, hv, sv);
      style = $urandom_range(0, 7);
      if (style == 0) begin
        n = $urandom_range(10, 30);
        repeat (n) pending_words.push_back(nnfs_pkg::in_word_t'(25'($urandom)));
      end else begin
        n_fetch = ow * oh;
        if (n_fetch > FETCH_CAP) n_fetch = FETCH_CAP;
        n_fetch += $urandom_range(0, 2);
        // Stop early so the next phase abandons the rest of the frame.
        if (style == 1 && n_fetch > 1) n_fetch = $urandom_range(1, n_fetch);
        if (style == 2) queue_fetches($urandom_range(1, 3));
        queue_loads(we * he);
        queue_fetches(n_fetch);
        n = we * he + n_fetch;
      end
      random_items += n;
    end
    settle();

    $display("Run covered %0d pixel loads and %0d fetches over %0d register settings.",
             loads_seen, fetches_seen, settings_used);
    $display("%0d output pixels checked, %0d complete output frames, %0d mismatches.",
             pixels_checked, frames_done, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
